FILE: src/mqtt_packet_framer_macros.svh
// Assertion macros shared by the framer's checker.
`ifndef MQTT_PACKET_FRAMER_MACROS_SVH
`define MQTT_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MPF_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("mqtt_packet_framer check failed");

// Next-cycle implication, disabled while reset is high.
`define MPF_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("mqtt_packet_framer check failed");

`endif

FILE: src/mpf_pkg.sv
// Types, constants and byte-generation functions of the MQTT packet framer.
package mpf_pkg;

  typedef enum logic [1:0] {
    OP_CONNECT = 2'd0,
    OP_PUBLISH = 2'd1,
    OP_DATA    = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_CONNECT,
    MODE_PUBLISH
  } mode_t;

  typedef enum logic [1:0] {
    CMD_CONNECT,
    CMD_PUBLISH,
    CMD_DATA
  } cmd_kind_t;

  localparam logic [7:0]  CONNECT_FIXED     = 8'h10;
  localparam logic [7:0]  PUBLISH_FIXED     = 8'h30;
  localparam logic [7:0]  VARINT_CONT       = 8'h80;
  localparam logic [7:0]  PROTO_NAME_LEN    = 8'h04;
  localparam logic [31:0] PROTO_NAME        = "MQTT";
  localparam logic [7:0]  PROTO_LEVEL       = 8'h04;
  localparam logic [7:0]  CONNECT_FLAGS     = 8'h02;
  localparam logic [17:0] CONNECT_VAR_LEN   = 18'd12;
  localparam logic [17:0] PUBLISH_VAR_LEN   = 18'd2;
  localparam logic [17:0] PACKET_ID_LEN     = 18'd2;
  localparam logic [1:0]  QOS_INVALID       = 2'd3;
  localparam logic [3:0]  CONNECT_HDR_BYTES = 4'd14;

  // One unit of work for the byte sequencer.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [17:0] remain;      // remaining length of the packet
    logic [1:0]  vcnt;        // varint byte count, 1 to 3
    logic [3:0]  count;       // bytes to emit for this transaction
    logic [15:0] keep_alive;
    logic [15:0] str_len;     // first string length
    logic [15:0] packet_id;
    logic [1:0]  qos;
    logic [7:0]  data_byte;
    logic [1:0]  defer_cnt;   // header bytes carried over from a long CONNECT
    logic        pkt_last;
  } cmd_t;

  function automatic logic [1:0] varint_len(logic [17:0] r);
    logic [1:0] n;
    if (r[17:14] != 4'd0) n = 2'd3;
    else if (r[13:7] != 7'd0) n = 2'd2;
    else n = 2'd1;
    return n;
  endfunction

  // Byte at position idx of the sequence that a command produces.
  function automatic logic [7:0] cmd_byte(cmd_t c, logic [3:0] idx);
    logic [3:0] v;
    logic [3:0] d;
    logic [3:0] j;
    logic [1:0] k;
    logic [6:0] dig;
    logic [7:0] b;
    v = {2'b00, c.vcnt};
    d = {2'b00, c.defer_cnt};
    j = 4'd0;
    k = 2'(idx - 4'd1);
    b = 8'h00;
    case (k)
      2'd0:    dig = c.remain[6:0];
      2'd1:    dig = c.remain[13:7];
      default: dig = {3'b000, c.remain[17:14]};
    endcase
    unique case (c.kind)
      CMD_CONNECT, CMD_PUBLISH: begin
        j = idx - v - 4'd1;
        if (idx == 4'd0) begin
          b = (c.kind == CMD_CONNECT) ? CONNECT_FIXED
                                      : (PUBLISH_FIXED | {5'b00000, c.qos, 1'b0});
        end else if (idx <= v) begin
          b = {1'b0, dig} | ((idx < v) ? VARINT_CONT : 8'h00);
        end else if (c.kind == CMD_CONNECT) begin
          case (j)
            4'd0:    b = 8'h00;
            4'd1:    b = PROTO_NAME_LEN;
            4'd2:    b = PROTO_NAME[31:24];
            4'd3:    b = PROTO_NAME[23:16];
            4'd4:    b = PROTO_NAME[15:8];
            4'd5:    b = PROTO_NAME[7:0];
            4'd6:    b = PROTO_LEVEL;
            4'd7:    b = CONNECT_FLAGS;
            4'd8:    b = c.keep_alive[15:8];
            4'd9:    b = c.keep_alive[7:0];
            4'd10:   b = c.str_len[15:8];
            4'd11:   b = c.str_len[7:0];
            default: b = 8'h00;
          endcase
        end else begin
          case (j)
            4'd0:    b = c.str_len[15:8];
            4'd1:    b = c.str_len[7:0];
            4'd2:    b = c.packet_id[15:8];
            default: b = c.packet_id[7:0];
          endcase
        end
      end
      CMD_DATA: begin
        j = idx - d;
        if (idx < d) begin
          b = (d == 4'd2 && idx == 4'd0) ? c.str_len[15:8] : c.str_len[7:0];
        end else begin
          case (j)
            4'd0:    b = c.data_byte;
            4'd1:    b = c.packet_id[15:8];
            default: b = c.packet_id[7:0];
          endcase
        end
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: src/mpf_front.sv
// Front end: accepts items, tracks the open packet and issues byte commands.
module mpf_front import mpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // first_length, payload_length, qos_level, packet_id, data_byte
  input  logic [1:0]  s_tuser,   // op
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output logic        push,
  output cmd_t        push_cmd,
  input  logic        queue_full
);

  logic [15:0] keep_alive;
  mode_t       mode, mode_next;
  logic [15:0] fsl, fsl_next;
  logic [15:0] pl, pl_next;
  logic        id_pending, id_pending_next;
  logic [15:0] held_pid, held_pid_next;
  logic [1:0]  defer_cnt, defer_cnt_next;

  logic        accept;
  op_t         op;
  logic [15:0] flen, plen, pid;
  logic [1:0]  qos_raw, qos;
  logic [7:0]  db;
  logic [17:0] conn_remain, pub_remain, remain;
  logic [1:0]  vcnt;
  logic        conn_last, pub_last, pub_pid_now;
  logic [15:0] fsl_dec, pl_dec;
  logic        pid_out, id_dec, data_last;

  assign s_tready  = !queue_full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  assign op      = op_t'(s_tuser);
  assign flen    = s_tdata[15:0];
  assign plen    = s_tdata[31:16];
  assign qos_raw = s_tdata[33:32];
  assign pid     = s_tdata[49:34];
  assign db      = s_tdata[57:50];
  assign qos     = (qos_raw == QOS_INVALID) ? 2'd0 : qos_raw;

  assign conn_remain = CONNECT_VAR_LEN + {2'b00, flen};
  assign pub_remain  = PUBLISH_VAR_LEN + {2'b00, flen} + {2'b00, plen}
                     + ((qos != 2'd0) ? PACKET_ID_LEN : 18'd0);
  assign remain      = (op == OP_CONNECT) ? conn_remain : pub_remain;
  assign vcnt        = varint_len(remain);

  assign conn_last   = (flen == 16'd0);
  assign pub_last    = (flen == 16'd0) && (plen == 16'd0);
  assign pub_pid_now = (qos != 2'd0) && (flen == 16'd0);

  // A data byte goes to the first string while it lasts, then to the payload.
  assign fsl_dec   = (fsl != 16'd0) ? fsl - 16'd1 : fsl;
  assign pl_dec    = (fsl == 16'd0 && pl != 16'd0) ? pl - 16'd1 : pl;
  assign pid_out   = (fsl == 16'd1) && id_pending;
  assign id_dec    = id_pending && !pid_out;
  assign data_last = (fsl_dec == 16'd0) && (pl_dec == 16'd0) && !id_dec;

  always_comb begin
    mode_next = mode;
    if (accept) begin
      unique case (op)
        OP_CONNECT: mode_next = conn_last ? MODE_IDLE : MODE_CONNECT;
        OP_PUBLISH: mode_next = pub_last ? MODE_IDLE : MODE_PUBLISH;
        OP_DATA: begin
          if (mode != MODE_IDLE && data_last) mode_next = MODE_IDLE;
        end
        default: mode_next = mode;
      endcase
    end
  end

  always_comb begin
    fsl_next        = fsl;
    pl_next         = pl;
    id_pending_next = id_pending;
    held_pid_next   = held_pid;
    defer_cnt_next  = defer_cnt;
    push            = 1'b0;
    push_cmd        = '{kind: CMD_DATA, remain: remain, vcnt: vcnt, count: 4'd1,
                        keep_alive: keep_alive, str_len: flen, packet_id: pid,
                        qos: qos, data_byte: db, defer_cnt: 2'd0, pkt_last: 1'b0};
    if (accept) begin
      unique case (op)
        OP_CONNECT: begin
          push              = 1'b1;
          push_cmd.kind     = CMD_CONNECT;
          push_cmd.count    = CONNECT_HDR_BYTES;
          push_cmd.pkt_last = conn_last;
          fsl_next          = flen;
          pl_next           = 16'd0;
          id_pending_next   = 1'b0;
          held_pid_next     = 16'd0;
          // Header bytes beyond the first fourteen wait for the next data byte.
          defer_cnt_next    = vcnt - 2'd1;
        end
        OP_PUBLISH: begin
          push              = 1'b1;
          push_cmd.kind     = CMD_PUBLISH;
          push_cmd.count    = 4'd3 + {2'b00, vcnt} + (pub_pid_now ? 4'd2 : 4'd0);
          push_cmd.pkt_last = pub_last;
          fsl_next          = flen;
          pl_next           = plen;
          id_pending_next   = (qos != 2'd0) && (flen != 16'd0);
          held_pid_next     = pid;
          defer_cnt_next    = 2'd0;
        end
        OP_DATA: begin
          if (mode != MODE_IDLE) begin
            push               = 1'b1;
            push_cmd.kind      = CMD_DATA;
            push_cmd.str_len   = fsl;
            push_cmd.packet_id = held_pid;
            push_cmd.defer_cnt = defer_cnt;
            push_cmd.count     = {2'b00, defer_cnt} + 4'd1 + (pid_out ? 4'd2 : 4'd0);
            push_cmd.pkt_last  = data_last;
            fsl_next           = fsl_dec;
            pl_next            = pl_dec;
            id_pending_next    = id_dec;
            defer_cnt_next     = 2'd0;
          end
        end
        default: push = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_alive <= 16'd60;
      mode       <= MODE_IDLE;
      fsl        <= 16'd0;
      pl         <= 16'd0;
      id_pending <= 1'b0;
      held_pid   <= 16'd0;
      defer_cnt  <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) keep_alive <= cfg_data;
      mode       <= mode_next;
      fsl        <= fsl_next;
      pl         <= pl_next;
      id_pending <= id_pending_next;
      held_pid   <= held_pid_next;
      defer_cnt  <= defer_cnt_next;
    end
  end

endmodule

FILE: src/mpf_queue.sv
// Two-entry command queue between the front end and the byte sequencer.
module mpf_queue import mpf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t       entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/mpf_back.sv
// Byte sequencer: expands each command into output bytes through a registered stage.
module mpf_back import mpf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  cmd_t       head_cmd,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_byte
  output logic [0:0] m_tuser,   // run_last
  output logic       m_tlast    // packet_last
);

  logic [3:0] idx, idx_next;
  logic       load, final_byte;

  assign load       = head_valid && (!m_tvalid || m_tready);
  assign final_byte = (idx == head_cmd.count - 4'd1);
  assign pop        = load && final_byte;

  always_comb begin
    idx_next = idx;
    if (load) idx_next = final_byte ? 4'd0 : idx + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 4'd0;
    end else begin
      idx <= idx_next;
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cmd_byte(head_cmd, idx);
      m_tuser <= final_byte;
      m_tlast <= final_byte && head_cmd.pkt_last;
    end
  end

endmodule

FILE: src/mqtt_packet_framer.sv
// Top level of the MQTT 3.1.1 CONNECT and PUBLISH byte-stream framer.
// A start item (op in s_tuser) opens a packet and yields its fixed header, the
// remaining length as a base-128 varint and the variable header; data items
// then pass the client id, topic and payload bytes through, with the packet id
// placed after the topic for PUBLISH at QoS 1 or 2. A front end takes one item
// per cycle while its two-entry command queue has room, and a byte sequencer
// drains the queue at one output byte per cycle unless m_tready stalls it, so
// the sequencer sets the rate: a data item yields 1 byte (3 when the packet id
// follows it, up to 2 more for header bytes held back from a long CONNECT), a
// CONNECT start 14 bytes and a PUBLISH start 4 to 8 bytes. When the sequencer
// is free, an accepted item goes into the queue, then its first byte into the
// output register. m_tuser marks the last byte of each input item and m_tlast
// the last byte of a packet. The keep-alive register is written through cfg_*.
module mqtt_packet_framer import mpf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // first_length, payload_length, qos_level, packet_id, data_byte
  input  logic [1:0]  s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic [0:0]  m_tuser,   // run_last
  output logic        m_tlast,   // packet_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // keep_alive_seconds
);

  logic push, queue_full, head_valid, pop;
  cmd_t push_cmd, head_cmd;

  mpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push       (push),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  mpf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  mpf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

endmodule

FILE: src/mpf_checker.sv
// Port-level checks of the framer, bound to the top level.
`include "mqtt_packet_framer_macros.svh"

module mpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [15:0] cfg_data
);

  // The end of a packet is always the end of the item that caused it.
  `MPF_ASSERT_NOW(a_pkt_end_is_run_end, clk, rst, m_tvalid && m_tlast, m_tuser[0])

  // Nothing is shown in the first cycle after reset.
  `MPF_ASSERT_NOW(a_quiet_after_reset, clk, rst, $past(rst), !m_tvalid)

  // A stalled transaction keeps its bytes and markers.
  `MPF_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

  // The configuration port never pushes back.
  `MPF_ASSERT_NOW(a_cfg_ready, clk, rst, cfg_valid, cfg_ready)

endmodule

bind mqtt_packet_framer mpf_checker u_mpf_checker (.*);

FILE: dv/testbench.sv
// Self-checking testbench for the MQTT CONNECT/PUBLISH byte-stream framer.
`timescale 1ns / 1ps

module testbench;
  import mpf_pkg::*;

  localparam int MAX_BEATS   = 14;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  typedef struct packed {
    op_t         op;
    logic [15:0] first_len;
    logic [15:0] pay_len;
    logic [1:0]  qos;
    logic [15:0] pkt_id;
    logic [7:0]  dbyte;
  } frame_req_t;

  typedef struct {
    logic [7:0] data;
    logic       item_end;
    logic       pkt_end;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // first_length, payload_length, qos_level, packet_id, data_byte
  logic [1:0]  s_tuser = '0;   // op
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // out_byte
  logic [0:0]  m_tuser;        // run_last
  logic        m_tlast;        // packet_last
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;  // keep_alive_seconds

  mqtt_packet_framer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Framer state as the predictor sees it.
  mode_t       mode = MODE_IDLE;
  logic [15:0] str_left = '0;
  logic [15:0] pay_left = '0;
  logic        id_owed = 1'b0;
  logic [15:0] id_hold = '0;
  int          carry_cnt = 0;
  logic [7:0]  carry [2];
  logic [15:0] keep_alive = 16'd60;

  frame_req_t  pending_q [$];
  beat_t       expected_beats [$];
  frame_req_t  on_bus;
  logic        steady = 1'b0;

  int items_queued = 0;
  int items_accepted = 0;
  int starts_seen = 0;
  int beats_checked = 0;
  int packets_closed = 0;
  int settings_used = 0;
  int mismatches = 0;
  int cycle_count = 0;

  function automatic frame_req_t rand_req(op_t op);
    frame_req_t r;
    r.op        = op;
    r.first_len = 16'($urandom);
    r.pay_len   = 16'($urandom);
    r.qos       = 2'($urandom);
    r.pkt_id    = 16'($urandom);
    r.dbyte     = 8'($urandom);
    return r;
  endfunction

  // Works out the bytes that one accepted item produces and updates the state.
  task automatic frame_item(frame_req_t r);
    logic [7:0]  hdr [$];
    logic [7:0]  outb [$];
    logic [17:0] rem;
    logic [1:0]  q;
    logic        close;
    int          k;
    if (r.op == OP_NONE) return;
    if (r.op == OP_DATA) begin
      if (mode == MODE_IDLE) return;
      for (k = 0; k < carry_cnt; k++) outb.push_back(carry[k]);
      carry_cnt = 0;
      if (str_left != 0) begin
        outb.push_back(r.dbyte);
        str_left--;
        if (str_left == 0 && id_owed) begin
          outb.push_back(id_hold[15:8]);
          outb.push_back(id_hold[7:0]);
          id_owed = 1'b0;
        end
      end else if (pay_left != 0) begin
        outb.push_back(r.dbyte);
        pay_left--;
      end
      if (outb.size() == 0) return;
    end else begin
      starts_seen++;
      carry_cnt = 0;
      q = 2'd0;
      if (r.op == OP_CONNECT) begin
        rem = CONNECT_VAR_LEN + 18'(r.first_len);
        hdr.push_back(CONNECT_FIXED);
      end else begin
        q = (r.qos == QOS_INVALID) ? 2'd0 : r.qos;
        rem = PUBLISH_VAR_LEN + 18'(r.first_len) + 18'(r.pay_len)
            + ((q != 2'd0) ? PACKET_ID_LEN : 18'd0);
        hdr.push_back(PUBLISH_FIXED | {5'b00000, q, 1'b0});
      end
      // Remaining length, seven bits per byte, continuation flag in bit 7.
      do begin
        hdr.push_back({|(rem >> 7), rem[6:0]});
        rem = rem >> 7;
      end while (rem != 0);
      if (r.op == OP_CONNECT) begin
        hdr.push_back(8'h00);
        hdr.push_back(PROTO_NAME_LEN);
        hdr.push_back(PROTO_NAME[31:24]);
        hdr.push_back(PROTO_NAME[23:16]);
        hdr.push_back(PROTO_NAME[15:8]);
        hdr.push_back(PROTO_NAME[7:0]);
        hdr.push_back(PROTO_LEVEL);
        hdr.push_back(CONNECT_FLAGS);
        hdr.push_back(keep_alive[15:8]);
        hdr.push_back(keep_alive[7:0]);
        hdr.push_back(r.first_len[15:8]);
        hdr.push_back(r.first_len[7:0]);
        mode     = MODE_CONNECT;
        str_left = r.first_len;
        pay_left = '0;
        id_owed  = 1'b0;
        id_hold  = '0;
      end else begin
        hdr.push_back(r.first_len[15:8]);
        hdr.push_back(r.first_len[7:0]);
        mode     = MODE_PUBLISH;
        str_left = r.first_len;
        pay_left = r.pay_len;
        id_hold  = r.pkt_id;
        id_owed  = (q != 2'd0);
        // With an empty topic the packet id goes out with the header.
        if (r.first_len == 0 && id_owed) begin
          hdr.push_back(r.pkt_id[15:8]);
          hdr.push_back(r.pkt_id[7:0]);
          id_owed = 1'b0;
        end
      end
      // Header bytes beyond what one item may produce wait for the next data item.
      foreach (hdr[k]) begin
        if (outb.size() < MAX_BEATS) begin
          outb.push_back(hdr[k]);
        end else if (carry_cnt < 2) begin
          carry[carry_cnt] = hdr[k];
          carry_cnt++;
        end
      end
    end
    close = (str_left == 0 && pay_left == 0 && !id_owed && carry_cnt == 0);
    if (close) mode = MODE_IDLE;
    foreach (outb[k]) begin
      expected_beats.push_back(beat_t'{outb[k], k == outb.size() - 1,
                                       close && (k == outb.size() - 1)});
    end
  endtask

  task automatic add_start(op_t op, int flen, int plen, int qos, int pid);
    frame_req_t r;
    r = rand_req(op);
    r.first_len = 16'(flen);
    r.pay_len   = 16'(plen);
    r.qos       = 2'(qos);
    r.pkt_id    = 16'(pid);
    pending_q.push_back(r);
    items_queued++;
  endtask

  // Data items; counted is 0 for bytes that the framer is expected to drop.
  task automatic add_data(int n, bit counted);
    for (int i = 0; i < n; i++) begin
      pending_q.push_back(rand_req(OP_DATA));
      if (counted) items_queued++;
    end
  endtask

  task automatic add_random_packet();
    int  sel;
    int  flen;
    int  plen;
    int  need;
    int  sent;
    op_t op;
    sel = $urandom_range(0, 99);
    op = ($urandom_range(0, 99) < 55) ? OP_PUBLISH : OP_CONNECT;
    if (sel < 70) begin
      flen = $urandom_range(0, 8);
      plen = $urandom_range(0, 12);
    end else if (sel < 90) begin
      flen = $urandom_range(9, 40);
      plen = $urandom_range(13, 40);
    end else begin
      flen = $urandom_range(0, 65535);
      plen = $urandom_range(0, 65535);
    end
    need = (op == OP_CONNECT) ? flen : flen + plen;
    sent = need;
    // Long packets are cut short by the next start to keep the run brief.
    if (need > 60) sent = $urandom_range(0, 6);
    else if ($urandom_range(0, 99) < 12) sent = $urandom_range(0, need);
    add_start(op, flen, plen, $urandom_range(0, 3), $urandom_range(0, 65535));
    if ($urandom_range(0, 99) < 5) pending_q.push_back(rand_req(OP_NONE));
    add_data(sent, 1'b1);
    if ($urandom_range(0, 99) < 10) add_data($urandom_range(1, 3), 1'b0);
  endtask

  task automatic settle();
    do @(posedge clk);
    while (pending_q.size() != 0 || s_tvalid || expected_beats.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_keep_alive(logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    keep_alive = v;
    settings_used++;
  endtask

  task automatic note_mismatch(string what, beat_t want, beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected byte %h run_last %b packet_last %b, got %h %b %b",
               $realtime, what, want.data, want.item_end, want.pkt_end,
               got.data, got.item_end, got.pkt_end);
    end
  endtask

  // Sender: holds an item until its transaction completes, otherwise may idle.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        frame_item(on_bus);
        items_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_q.size() != 0 && (steady || $urandom_range(0, 99) >= 25)) begin
          on_bus = pending_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {6'b000000, on_bus.dbyte, on_bus.pkt_id, on_bus.qos,
                       on_bus.pay_len, on_bus.first_len};
          s_tuser  <= on_bus.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure and checking of each output transaction.
  always @(posedge clk) begin
    beat_t got;
    beat_t want;
    m_tready <= steady || ($urandom_range(0, 99) >= 25);
    if (!rst && m_tvalid && m_tready) begin
      got = beat_t'{m_tdata, m_tuser[0], m_tlast};
      beats_checked++;
      if (m_tlast === 1'b1) packets_closed++;
      if (expected_beats.size() == 0) begin
        note_mismatch("output with nothing expected", beat_t'{8'h00, 1'b0, 1'b0}, got);
      end else begin
        want = expected_beats.pop_front();
        if (got.data !== want.data || got.item_end !== want.item_end
            || got.pkt_end !== want.pkt_end) begin
          note_mismatch("output mismatch", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with the keep-alive still at its reset value.
    add_data(1, 1'b0);                        // data with no packet open
    pending_q.push_back(rand_req(OP_NONE));
    add_start(OP_CONNECT, 0, 0, 0, 0);        // whole packet from the start item
    add_start(OP_PUBLISH, 0, 0, 0, 16'h1234);
    add_start(OP_PUBLISH, 0, 0, 1, 16'hFFFF); // empty topic, id with the header
    add_start(OP_PUBLISH, 0, 1, 2, 16'h0000);
    add_data(1, 1'b1);
    add_start(OP_PUBLISH, 2, 2, 3, 16'h00FF); // invalid QoS becomes 0
    add_data(4, 1'b1);
    add_data(1, 1'b0);                        // beyond the declared lengths
    add_start(OP_PUBLISH, 1, 0, 1, 16'hA5C3);
    add_data(1, 1'b1);
    add_start(OP_CONNECT, 116, 0, 0, 0);      // one header byte held back
    add_data(2, 1'b1);
    add_start(OP_CONNECT, 65535, 0, 0, 0);    // two held back, then aborted
    add_start(OP_PUBLISH, 65535, 65535, 2, 16'h8001);
    add_data(2, 1'b1);
    add_start(OP_CONNECT, 3, 0, 0, 0);
    pending_q.push_back(rand_req(OP_NONE));
    add_data(3, 1'b1);
    add_data(1, 1'b0);
    settle();

    write_keep_alive(16'hFFFF);
    add_start(OP_CONNECT, 117, 0, 0, 0);      // long client id sent in full
    add_data(117, 1'b1);
    while (items_queued < 170) add_random_packet();
    settle();

    // No idling on either side for this stretch.
    write_keep_alive(16'h0000);
    steady = 1'b1;
    while (items_queued < 250) add_random_packet();
    settle();
    steady = 1'b0;

    write_keep_alive(16'($urandom_range(1, 65534)));
    while (items_queued < 310) add_random_packet();
    settle();

    $display("Accepted %0d input items (%0d packet starts) under %0d keep-alive settings.",
             items_accepted, starts_seen, settings_used + 1);
    $display("Checked %0d output bytes, %0d packets closed, %0d mismatches.",
             beats_checked, packets_closed, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/mpf_pkg.sv
src/mpf_front.sv
src/mpf_queue.sv
src/mpf_back.sv
src/mqtt_packet_framer.sv
src/mpf_checker.sv
dv/testbench.sv
